// ----- design/trm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed mean unit package
// Payload types, status codes, sequencer states and sizing constants.
// ----------------------------------------------------------------------------
package trm_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int SAMPLE_W    = 16;
   localparam int TRIM_W      = 6;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W       = SAMPLE_W + CNT_W;
   localparam int WIDE_W      = CNT_W + TRIM_W + 1;
   localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TRIM     = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_value;
      logic                       last_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mean_value;
      status_type                 status;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_KEY,
      S_LOAD,
      S_SCAN,
      S_ACC,
      S_DIV,
      S_DONE
   } state_type;

endpackage

// ----- design/trimmed_mean_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed mean unit
// Stores a block of signed samples, ranks each one against the others with a
// single comparator, sums the samples whose rank survives the trim, and
// divides by the kept count with a one-bit-per-cycle restoring divider.
//
//   Channel   Ports                                   Dir   Moves
//   req       req_valid, req_stall, req_payload       in    one sample
//   rsp       rsp_valid, rsp_stall, rsp_payload       out   mean and status
//   csr       csr_write_en, csr_write_data            in    trim_count
//
// A sample without the last mark leaves the unit idle, ready for the next sample.
// A last sample of a valid block starts the rank scan, which reads the sample
// memory once per comparison; then the divider retires one quotient bit per
// cycle. An overflowed or over-trimmed block goes straight to the done state.
// Reset is synchronous and clears the sequencer, sample count, overflow flag,
// result valid and trim register. req_stall is high while a block is being
// worked; rsp_stall holds the finished result in its output register, and a
// later result waits in the done state until that transfer completes.
// ----------------------------------------------------------------------------
module trimmed_mean_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  trm_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output trm_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_write_en,
   input  logic [trm_pkg::TRIM_W-1:0] csr_write_data
);
   import trm_pkg::*;

   logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];

   state_type                  state_ff, state_in;
   logic [TRIM_W-1:0]          trim_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       ovf_ff, ovf_in;
   logic [CNT_W-1:0]           num_ff, num_in;
   logic [CNT_W-1:0]           i_ff, i_in;
   logic [CNT_W-1:0]           j_ff, j_in;
   logic [CNT_W-1:0]           rank_ff, rank_in;
   logic signed [SAMPLE_W-1:0] key_ff, key_in;
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]           quo_ff, quo_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]           kept_ff, kept_in;
   logic                       neg_ff, neg_in;
   logic [DIV_CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   status_type                 stat_ff, stat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_ff, rsp_in;

   logic                       req_xfer;
   logic                       mem_we;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       full;
   logic [CNT_W-1:0]           total;
   logic [WIDE_W-1:0]          dbl_trim_w;
   logic [WIDE_W-1:0]          total_w;
   logic [WIDE_W-1:0]          hi_w;
   logic [WIDE_W-1:0]          rank_w;
   logic                       lower;
   logic [CNT_W:0]             shifted;
   logic                       fits;
   logic [SUM_W-1:0]           mag_sel;
   logic [CNT_W-1:0]           j_next;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_xfer    = req_valid && !req_stall;
   assign full        = (count_ff == CNT_W'(MAX_SAMPLES));
   assign mem_we      = req_xfer && !full;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign j_next      = j_ff + CNT_W'(1);

   assign dbl_trim_w = {WIDE_W'(trim_ff)} << 1;
   assign hi_w       = WIDE_W'(num_ff) - WIDE_W'(trim_ff);
   assign rank_w     = WIDE_W'(rank_ff);
   assign lower      = (rd_ff < key_ff) || ((rd_ff == key_ff) && (j_ff < i_ff));
   assign shifted    = {rem_ff, quo_ff[SUM_W-1]};
   assign fits       = (shifted >= {1'b0, kept_ff});
   assign mag_sel    = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ADDR_W-1:0]] <= req_payload.sample_value;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         trim_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            trim_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      rank_ff    <= rank_in;
      key_ff     <= key_in;
      sum_ff     <= sum_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      kept_ff    <= kept_in;
      neg_ff     <= neg_in;
      div_cnt_ff <= div_cnt_in;
      stat_ff    <= stat_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      num_in       = num_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rank_in      = rank_ff;
      key_in       = key_ff;
      sum_in       = sum_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      kept_in      = kept_ff;
      neg_in       = neg_ff;
      div_cnt_in   = div_cnt_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_addr      = j_next[ADDR_W-1:0];
      total        = count_ff + CNT_W'(!full);
      total_w      = WIDE_W'(total);

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               count_in = total;
               ovf_in   = ovf_ff || full;
               if (req_payload.last_sample) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  num_in   = total;
                  i_in     = '0;
                  sum_in   = '0;
                  if (ovf_ff || full) begin
                     stat_in  = STATUS_OVERFLOW;
                     quo_in   = '0;
                     neg_in   = 1'b0;
                     state_in = S_DONE;
                  end else if (dbl_trim_w >= total_w) begin
                     stat_in  = STATUS_TRIM;
                     quo_in   = '0;
                     neg_in   = 1'b0;
                     state_in = S_DONE;
                  end else begin
                     stat_in  = STATUS_OK;
                     kept_in  = CNT_W'(total_w - dbl_trim_w);
                     state_in = S_KEY;
                  end
               end
            end
         end
         S_KEY: begin
            rd_addr  = i_ff[ADDR_W-1:0];
            state_in = S_LOAD;
         end
         S_LOAD: begin
            rd_addr  = '0;
            key_in   = rd_ff;
            j_in     = '0;
            rank_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            rank_in = rank_ff + CNT_W'(lower);
            j_in    = j_next;
            if (j_next == num_ff) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if ((rank_w >= WIDE_W'(trim_ff)) && (rank_w < hi_w)) begin
               sum_in = sum_ff + SUM_W'(key_ff);
            end
            i_in = i_ff + CNT_W'(1);
            if (i_ff + CNT_W'(1) == num_ff) begin
               state_in = S_DIV;
               div_cnt_in = '0;
               rem_in     = '0;
            end else begin
               state_in = S_KEY;
            end
         end
         S_DIV: begin
            if (div_cnt_ff == '0 && rem_ff == '0 && i_ff == num_ff) begin
               neg_in = sum_ff[SUM_W-1];
               quo_in = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
               i_in   = '0;
            end else begin
               rem_in     = fits ? CNT_W'(shifted - {1'b0, kept_ff}) : CNT_W'(shifted);
               quo_in     = {quo_ff[SUM_W-2:0], fits};
               div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = stat_ff;
               rsp_in.mean_value = (stat_ff == STATUS_OK) ? mag_sel[SAMPLE_W-1:0] : '0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (rank_ff <= j_ff))
      else $error("rank exceeds compared samples");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result raised outside done state");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STATUS_OK) |-> (rsp_payload.mean_value == '0))
      else $error("nonzero mean on failed block");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC) |-> (rank_ff < num_ff))
      else $error("rank out of range at accumulate");

endmodule

// ----- tb/sv/mean_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed mean scoreboard
// Keeps its own copy of the sample block, the overflow flag and the trim
// setting. On every last sample it queues the expected mean and status; when
// the block is valid it first orders it and sums the samples that survive the
// trim. Results from the unit are compared in order against that queue.
// ----------------------------------------------------------------------------
class mean_tracker;

   logic signed [trm_pkg::SAMPLE_W-1:0] block_samples [trm_pkg::MAX_SAMPLES];
   int unsigned                         sample_count;
   bit                                  overflowed;
   int unsigned                         trim;
   trm_pkg::rsp_payload_type            expected_means [$];
   int unsigned                         mismatches;
   int unsigned                         results_seen;
   int unsigned                         status_hits [3];

   function new();
      sample_count = 0;
      overflowed   = 1'b0;
      trim         = 0;
      mismatches   = 0;
      results_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
   endfunction

   function void set_trim(int unsigned value);
      trim = value;
   endfunction

   function int unsigned pending();
      return expected_means.size();
   endfunction

   function trm_pkg::rsp_payload_type block_mean();
      trm_pkg::rsp_payload_type            mean;
      logic signed [trm_pkg::SAMPLE_W-1:0] ordered [trm_pkg::MAX_SAMPLES];
      logic signed [trm_pkg::SAMPLE_W-1:0] key;
      longint                              total;
      int                                  j;
      mean.mean_value = '0;
      if (overflowed) begin
         mean.status = trm_pkg::STATUS_OVERFLOW;
      end else if (2 * trim >= sample_count) begin
         mean.status = trm_pkg::STATUS_TRIM;
      end else begin
         for (int i = 0; i < sample_count; i++) ordered[i] = block_samples[i];
         for (int i = 1; i < sample_count; i++) begin
            key = ordered[i];
            j   = i;
            while (j > 0 && ordered[j-1] > key) begin
               ordered[j] = ordered[j-1];
               j--;
            end
            ordered[j] = key;
         end
         total = 0;
         for (int i = trim; i < sample_count - trim; i++) total += ordered[i];
         mean.mean_value = 16'(total / longint'(sample_count - 2 * trim));
         mean.status     = trm_pkg::STATUS_OK;
      end
      return mean;
   endfunction

   function void note_sample(logic signed [trm_pkg::SAMPLE_W-1:0] value, logic last);
      if (sample_count < trm_pkg::MAX_SAMPLES) begin
         block_samples[sample_count] = value;
         sample_count++;
      end else begin
         overflowed = 1'b1;
      end
      if (last) begin
         expected_means.push_back(block_mean());
         sample_count = 0;
         overflowed   = 1'b0;
      end
   endfunction

   function void check_mean(trm_pkg::rsp_payload_type got);
      trm_pkg::rsp_payload_type want;
      results_seen++;
      if (expected_means.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] unexpected result: mean %0d status %0d",
                     $time, got.mean_value, got.status);
         return;
      end
      want = expected_means.pop_front();
      status_hits[want.status]++;
      if (got.mean_value !== want.mean_value || got.status !== want.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] result %0d: expected mean %0d status %0d, got mean %0d status %0d",
                     $time, results_seen, want.mean_value, want.status,
                     got.mean_value, got.status);
      end
   endfunction

endclass

// ----- tb/sv/trimmed_mean_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed mean unit testbench
// Sends blocks of signed samples with random sender gaps and receiver stalls,
// moves the trim setting between phases while the unit is idle, and checks
// every mean and status against the scoreboard. A short directed part covers
// the sample extremes, rounding toward zero and over-trimmed blocks; the
// random part adds full, overflowed and trim-sized blocks.
// ----------------------------------------------------------------------------
module trimmed_mean_unit_tb;

   import trm_pkg::*;

   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   req_payload_type     req_payload    = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   rsp_payload_type     rsp_payload;
   logic                csr_write_en   = 1'b0;
   logic [TRIM_W-1:0]   csr_write_data = '0;

   mean_tracker         board;
   int unsigned         send_idle_pct;
   int unsigned         recv_stall_pct;
   int unsigned         items_sent;
   int unsigned         blocks_sent;
   int unsigned         trim_writes;
   int unsigned         trim_plan [9];
   int unsigned         drain_cycles;

   trimmed_mean_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return SAMPLE_W'($urandom);
      if (roll < 72) begin
         case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      return SAMPLE_W'($urandom_range(0, 40)) - 16'sd20;
   endfunction

   function automatic int unsigned random_size(int unsigned trim);
      int unsigned roll;
      int unsigned n;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 12);
      if (roll < 96) begin
         n = 2 * trim + $urandom_range(1, 6);
         return (n > MAX_SAMPLES) ? MAX_SAMPLES : n;
      end
      if (roll < 98) return MAX_SAMPLES;
      return MAX_SAMPLES + $urandom_range(1, 3);
   endfunction

   task automatic send_sample(logic signed [SAMPLE_W-1:0] value, logic last);
      req_payload_type item;
      item.sample_value = value;
      item.last_sample  = last;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_sample(value, last);
      items_sent++;
      if (last) blocks_sent++;
   endtask

   task automatic sample_block(int unsigned n);
      for (int unsigned i = 0; i < n; i++) send_sample(random_sample(), i == n - 1);
   endtask

   task automatic set_trim(int unsigned value);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= TRIM_W'(value);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      board.set_trim(value);
      trim_writes++;
   endtask

   // check each result transfer, then pick the next stall
   initial begin
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            board.check_mean(rsp_payload);
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   initial begin
      #5ms;
      $display("trimmed_mean_unit verification failed");
      $finish;
   end

   initial begin
      board          = new();
      items_sent     = 0;
      blocks_sent    = 0;
      trim_writes    = 0;
      send_idle_pct  = 11;
      recv_stall_pct = 58;
      trim_plan      = '{0, 5, 31, 32, 1, 0, 0, 2, 16};
      trim_plan[5]   = $urandom_range(0, 32);
      trim_plan[6]   = $urandom_range(0, 32);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_trim(0);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b1);
      send_sample(-16'sd1, 1'b0);
      send_sample(-16'sd2, 1'b1);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh7FFE, 1'b1);

      set_trim(1);
      send_sample(16'sd5, 1'b0);
      send_sample(16'sd7, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sd100, 1'b0);
      send_sample(-16'sd5, 1'b1);
      send_sample(-16'sd3, 1'b0);
      send_sample(-16'sd3, 1'b0);
      send_sample(-16'sd3, 1'b1);

      set_trim(32);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b1);

      for (int s = 0; s < 9; s++) begin
         send_idle_pct  = (s < 3) ? 11 : (s < 6) ? 58 : 0;
         recv_stall_pct = (s < 3) ? 58 : (s < 6) ? 11 : 0;
         set_trim(trim_plan[s]);
         if (s == 2) sample_block(MAX_SAMPLES);
         if (s == 4) sample_block(MAX_SAMPLES + 1);
         while (items_sent < 19 + (s + 1) * 104) sample_block(random_size(trim_plan[s]));
      end

      req_valid <= 1'b0;
      drain_cycles = 0;
      while (board.pending() != 0 && drain_cycles < 50000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (30) @(posedge clock);
      if (board.pending() != 0) begin
         $display("%0d expected results never arrived", board.pending());
         board.mismatches += board.pending();
      end

      $display("Sent %0d samples in %0d blocks across %0d trim settings.",
               items_sent, blocks_sent, trim_writes);
      $display("Checked %0d results: %0d ok, %0d over-trimmed, %0d overflowed.",
               board.results_seen, board.status_hits[STATUS_OK],
               board.status_hits[STATUS_TRIM], board.status_hits[STATUS_OVERFLOW]);
      if (board.mismatches == 0) begin
         $display("trimmed_mean_unit verification clean");
      end else begin
         $display("trimmed_mean_unit verification failed");
      end
      $finish;
   end

endmodule
